// ----- rtl/core/file_type_header_stripper_defines.svh -----
// ----------------------------------------------------------------------------
// file_type_header_stripper_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FILE_TYPE_HEADER_STRIPPER_DEFINES_SVH
`define FILE_TYPE_HEADER_STRIPPER_DEFINES_SVH

// same-cycle implication
`define FTHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fths_pkg.sv -----
// ----------------------------------------------------------------------------
// fths_pkg
// Types and constants of the file type header stripper.
// ----------------------------------------------------------------------------
package fths_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FILE_TYPE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKED_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APPLESOFT_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGER_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_CODE      = 3'd5;

    localparam logic [2:0] HLEN_NONE   = 3'd0;
    localparam logic [2:0] HLEN_TOKEN  = 3'd2;
    localparam logic [2:0] HLEN_BINARY = 3'd4;

    typedef struct packed {
        logic [7:0] file_type;
        logic [7:0] locked_mask;
        logic [7:0] binary_code;
        logic [7:0] applesoft_code;
        logic [7:0] integer_code;
        logic [7:0] text_code;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       eof;
    } res_t;

    // up to three results caused by one input byte
    typedef struct packed {
        logic [1:0]  cnt;
        res_t [2:0]  ent;
        logic [15:0] addr;
        logic        known;
    } bundle_t;

endpackage

// ----- rtl/core/file_type_header_stripper.sv -----
// ----------------------------------------------------------------------------
// file_type_header_stripper
// Strips the type-dependent header of a file byte stream.
// ----------------------------------------------------------------------------
// Input stream carries raw file bytes in tdata[7:0], tlast on the final byte.
// Output stream carries content bytes: tdata = {load_address, out_byte},
// tuser = {has_load_address, byte_valid}, tlast = end_of_file. A request with
// byte_valid low is only the end-of-file marker of a file whose last byte
// was dropped.
// Configuration registers (type byte, lock mask, type codes) are written through
// cfg_wen/cfg_index/cfg_wdata, by the user between files; the block does not check.
// A byte accepted goes into the input register; once the result register is free,
// its bundle is loaded there and its first request is offered from it.
// Throughput: one byte per cycle unless output stalls; an input register feeds the
// header logic and a result register; one more byte is taken while a result waits.
// A file that ends inside its header returns up to three requests for its
// last byte; the result register holds them and input stalls for those cycles.
// An output stall backs up through the result and input registers.
// Reset clears the per-file state and returns the registers to defaults.
// ----------------------------------------------------------------------------
module file_type_header_stripper
    import fths_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // in_byte[7:0]
    input  logic                 s_axis_tlast,   // in_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // out_byte[7:0], load_address[23:8]
    output logic [1:0]           m_axis_tuser,   // byte_valid[0], has_load_address[1]
    output logic                 m_axis_tlast    // end_of_file
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       advance;
    bundle_t    bundle;

    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.file_type      <= 8'd0;
            cfg_reg.locked_mask    <= 8'd128;
            cfg_reg.binary_code    <= 8'd4;
            cfg_reg.applesoft_code <= 8'd2;
            cfg_reg.integer_code   <= 8'd1;
            cfg_reg.text_code      <= 8'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_FILE_TYPE:      cfg_reg.file_type      <= cfg_wdata;
                REG_LOCKED_MASK:    cfg_reg.locked_mask    <= cfg_wdata;
                REG_BINARY_CODE:    cfg_reg.binary_code    <= cfg_wdata;
                REG_APPLESOFT_CODE: cfg_reg.applesoft_code <= cfg_wdata;
                REG_INTEGER_CODE:   cfg_reg.integer_code   <= cfg_wdata;
                REG_TEXT_CODE:      cfg_reg.text_code      <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    fths_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .bundle  (bundle)
    );

    fths_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .bundle        (bundle),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/core/fths_core.sv -----
// ----------------------------------------------------------------------------
// fths_core
// Per-file state and the per-byte decision; builds the result bundle.
// ----------------------------------------------------------------------------
module fths_core
    import fths_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output bundle_t    bundle
);

    logic [7:0]  store_reg [3];
    logic [2:0]  seen_reg, seen_next;
    logic [15:0] claimed_reg, claimed_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        ended_reg, ended_next;
    logic [15:0] addr_reg, addr_next;
    logic        known_reg, known_next;

    logic [7:0]  ftype;
    logic [2:0]  hlen;
    logic        store_we;
    logic [2:0]  seen_upd;
    logic [15:0] claimed_upd, emitted_upd, addr_upd;
    logic        ended_upd, known_upd, emit, do_clear;

    always_comb
    begin
        ftype = cfg.file_type & ~cfg.locked_mask;
        if (ftype == cfg.binary_code)
            hlen = HLEN_BINARY;
        else if (ftype == cfg.applesoft_code || ftype == cfg.integer_code)
            hlen = HLEN_TOKEN;
        else
            hlen = HLEN_NONE;

        store_we    = 1'b0;
        seen_upd    = seen_reg;
        claimed_upd = claimed_reg;
        emitted_upd = emitted_reg;
        ended_upd   = ended_reg;
        addr_upd    = addr_reg;
        known_upd   = known_reg;
        emit        = 1'b0;
        do_clear    = in_last;

        bundle.cnt   = 2'd0;
        bundle.ent   = '0;
        bundle.addr  = '0;
        bundle.known = 1'b0;

        if (hlen != HLEN_NONE && seen_reg < hlen)
        begin
            if ({1'b0, seen_reg} + 4'd1 < {1'b0, hlen})
            begin
                if (in_last)
                begin
                    // short file: replay stored header bytes, then this one
                    bundle.cnt = seen_reg[1:0] + 2'd1;
                    if (seen_reg != 3'd0)
                        bundle.ent[0] = '{valid: 1'b1, data: store_reg[0], eof: 1'b0};
                    if (seen_reg == 3'd2)
                        bundle.ent[1] = '{valid: 1'b1, data: store_reg[1], eof: 1'b0};
                    bundle.ent[seen_reg[1:0]] = '{valid: 1'b1, data: in_byte, eof: 1'b1};
                end
                else
                begin
                    store_we = 1'b1;
                    seen_upd = seen_reg + 3'd1;
                end
            end
            else
            begin
                if (hlen == HLEN_BINARY)
                begin
                    addr_upd    = {store_reg[1], store_reg[0]};
                    known_upd   = 1'b1;
                    claimed_upd = {in_byte, store_reg[2]};
                end
                else
                begin
                    claimed_upd = {in_byte, store_reg[0]};
                end
                seen_upd    = hlen;
                emitted_upd = '0;
            end
        end
        else if (hlen != HLEN_NONE)
        begin
            if (emitted_reg < claimed_reg)
            begin
                emit        = 1'b1;
                emitted_upd = emitted_reg + 16'd1;
            end
        end
        else if (ftype == cfg.text_code)
        begin
            if (!ended_reg)
            begin
                if (in_byte == 8'd0)
                    ended_upd = 1'b1;
                else
                    emit = 1'b1;
            end
        end
        else
        begin
            emit = 1'b1;
        end

        if (bundle.cnt == 2'd0 && (emit || in_last))
        begin
            bundle.cnt    = 2'd1;
            bundle.ent[0] = '{valid: emit, data: emit ? in_byte : 8'd0, eof: in_last};
        end
        bundle.known = known_upd;
        bundle.addr  = known_upd ? addr_upd : 16'd0;

        seen_next    = do_clear ? 3'd0  : seen_upd;
        claimed_next = do_clear ? 16'd0 : claimed_upd;
        emitted_next = do_clear ? 16'd0 : emitted_upd;
        ended_next   = do_clear ? 1'b0  : ended_upd;
        addr_next    = do_clear ? 16'd0 : addr_upd;
        known_next   = do_clear ? 1'b0  : known_upd;
    end

    always_ff @(posedge clk)
    begin
        if (step && store_we)
            store_reg[seen_reg[1:0]] <= in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            claimed_reg <= '0;
            emitted_reg <= '0;
            ended_reg   <= 1'b0;
            addr_reg    <= '0;
            known_reg   <= 1'b0;
        end
        else if (step)
        begin
            seen_reg    <= seen_next;
            claimed_reg <= claimed_next;
            emitted_reg <= emitted_next;
            ended_reg   <= ended_next;
            addr_reg    <= addr_next;
            known_reg   <= known_next;
        end
    end

endmodule

// ----- rtl/core/fths_out.sv -----
// ----------------------------------------------------------------------------
// fths_out
// Result register: holds one bundle and hands its results out one per request.
// ----------------------------------------------------------------------------
module fths_out
    import fths_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bundle_t     bundle,
    output logic        free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], load_address[23:8]
    output logic [1:0]  m_axis_tuser,   // byte_valid[0], has_load_address[1]
    output logic        m_axis_tlast    // end_of_file
);

    logic [1:0]  cnt_reg;
    logic [1:0]  head_reg;
    res_t [2:0]  ent_reg;
    logic [15:0] addr_reg;
    logic        known_reg;
    res_t        cur;
    logic        take;

    assign cur           = ent_reg[head_reg];
    assign take          = m_axis_tvalid && m_axis_tready;
    assign free          = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {addr_reg, cur.data};
    assign m_axis_tuser  = {known_reg, cur.valid};
    assign m_axis_tlast  = cur.eof;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg   <= bundle.ent;
            addr_reg  <= bundle.addr;
            known_reg <= bundle.known;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            head_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg  <= bundle.cnt;
            head_reg <= '0;
        end
        else if (take)
        begin
            cnt_reg  <= cnt_reg - 2'd1;
            head_reg <= head_reg + 2'd1;
        end
    end

endmodule

// ----- rtl/core/fths_checker.sv -----
// ----------------------------------------------------------------------------
// fths_checker
// Port-level assertions for file_type_header_stripper.
// ----------------------------------------------------------------------------
`include "file_type_header_stripper_defines.svh"

module fths_checker
    import fths_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `FTHS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast), "output request changed while stalled")

    `FTHS_ASSERT_IMP(a_empty_byte_zero, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[7:0] == 8'd0, "byte not zero on an empty request")

    `FTHS_ASSERT_IMP(a_addr_zero, m_axis_tvalid && !m_axis_tuser[1],
        m_axis_tdata[23:8] == 16'd0, "load address not zero while unknown")

    `FTHS_ASSERT_IMP(a_empty_is_eof, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tlast, "empty request that is not end of file")

endmodule

bind file_type_header_stripper fths_checker u_fths_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
